// File: hdl/ffca_pkg.sv
package ffca_pkg;

   localparam int MAX_CHUNKS = 32;
   localparam int ADDR_BITS  = 16;

   localparam int SIZE_W  = 10;
   localparam int HEAP_W  = 17;
   localparam int CTR_W   = 32;
   localparam int STAT_W  = 3;
   localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
   localparam int SLOT_W  = CNT_W + 1;
   localparam int BUMP_W  = ADDR_BITS + 1;
   localparam int CMP_W   = (ADDR_BITS + 2 > HEAP_W + 1) ? ADDR_BITS + 2 : HEAP_W + 1;

   localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(65536);

   localparam logic [SIZE_W-1:0] CLASS_32  = SIZE_W'(32);
   localparam logic [SIZE_W-1:0] CLASS_64  = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] CLASS_128 = SIZE_W'(128);
   localparam logic [SIZE_W-1:0] CLASS_256 = SIZE_W'(256);
   localparam logic [SIZE_W-1:0] CLASS_512 = SIZE_W'(512);

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_REUSED    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NEW       = 3'd1;
   localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

   typedef enum logic [0:0] {
      FSM_IDLE,
      FSM_UPDATE
   } state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_W-1:0]    size;
   } entry_type;

   typedef struct packed {
      logic match_en;
      logic remove;
      logic append;
   } free_ctl_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   function automatic logic [SIZE_W-1:0] size_class(input logic [SIZE_W-1:0] req);
      logic [SIZE_W-1:0] cls;
      if (req <= CLASS_32) begin
         cls = CLASS_32;
      end else if (req <= CLASS_64) begin
         cls = CLASS_64;
      end else if (req <= CLASS_128) begin
         cls = CLASS_128;
      end else if (req <= CLASS_256) begin
         cls = CLASS_256;
      end else begin
         cls = CLASS_512;
      end
      return cls;
   endfunction

endpackage

// File: hdl/ffca_free_cell.sv
module ffca_free_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  ffca_pkg::free_ctl_type            ctl,
   input  logic                              occupied,
   input  logic                              tail,
   input  logic [ffca_pkg::SIZE_W-1:0]       req_size,
   input  ffca_pkg::entry_type               app_entry,
   input  ffca_pkg::entry_type               nbr_entry,
   input  logic                              taken_in,
   output logic                              taken_out,
   output logic                              sel,
   output ffca_pkg::entry_type               entry
);

   ffca_pkg::entry_type entry_ff, entry_in;
   logic                match_ff, match_in;

   assign taken_out = taken_in | match_ff;
   assign sel       = match_ff & ~taken_in;
   assign entry     = entry_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.match_en) begin
         match_in = occupied && (entry_ff.size >= req_size);
      end
      entry_in = entry_ff;
      // close the gap: every cell at or past the removed one pulls from its neighbor
      if (ctl.remove && taken_out) begin
         entry_in = nbr_entry;
      end else if (ctl.append && tail) begin
         entry_in = app_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/ffca_free_chain.sv
module ffca_free_chain (
   input  logic                              clock,
   input  logic                              reset,
   input  ffca_pkg::free_ctl_type            ctl,
   input  logic [ffca_pkg::SIZE_W-1:0]       req_size,
   input  ffca_pkg::entry_type               app_entry,
   input  logic [ffca_pkg::CNT_W-1:0]        free_cnt,
   output logic                              found,
   output ffca_pkg::entry_type               sel_entry
);

   localparam int N = ffca_pkg::MAX_CHUNKS;

   logic [N:0]          taken;
   logic [N-1:0]        sel;
   ffca_pkg::entry_type entry [N];
   ffca_pkg::entry_type nbr   [N];

   assign taken[0] = 1'b0;
   assign found    = taken[N];

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i < N - 1) begin : g_mid
         assign nbr[i] = entry[i+1];
      end else begin : g_last
         assign nbr[i] = entry[i];
      end

      ffca_free_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .occupied  (ffca_pkg::CNT_W'(i) < free_cnt),
         .tail      (ffca_pkg::CNT_W'(i) == free_cnt),
         .req_size  (req_size),
         .app_entry (app_entry),
         .nbr_entry (nbr[i]),
         .taken_in  (taken[i]),
         .taken_out (taken[i+1]),
         .sel       (sel[i]),
         .entry     (entry[i])
      );
   end

   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < N; i++) begin
         sel_entry = sel_entry | (entry[i] & {$bits(ffca_pkg::entry_type){sel[i]}});
      end
   end

endmodule

// File: hdl/ffca_used_stack.sv
module ffca_used_stack (
   input  logic                   clock,
   input  ffca_pkg::stack_ctl_type ctl,
   input  ffca_pkg::entry_type    push_entry,
   output ffca_pkg::entry_type    top
);

   localparam int N = ffca_pkg::MAX_CHUNKS;

   ffca_pkg::entry_type cell_ff [N];
   ffca_pkg::entry_type cell_in [N];

   assign top = cell_ff[0];

   // push shifts every cell one place deeper, pop shifts toward the top
   always_comb begin
      for (int i = 0; i < N; i++) begin
         cell_in[i] = cell_ff[i];
         if (ctl.push) begin
            cell_in[i] = (i == 0) ? push_entry : cell_ff[(i == 0) ? 0 : i - 1];
         end else if (ctl.pop) begin
            cell_in[i] = (i == N - 1) ? cell_ff[i] : cell_ff[(i == N - 1) ? i : i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

endmodule

// File: hdl/first_fit_chunk_allocator.sv
// First-fit chunk allocator.
// Request channel (req_valid/req_ready): req_func selects allocate or free,
// req_req_size gives the requested bytes. Result channel (rsp_valid/rsp_ready)
// returns address, chunk size, status and both request counters, one result
// per request. csr_wr_en/csr_wr_data write the heap limit; write it only while
// no request is in flight.
// An allocate takes the oldest free chunk that is large enough; otherwise it
// carves a size-class chunk (32..512 bytes) at the bump pointer. A free pops
// the most recent allocation and appends it to the free list.
// Each request has an accept cycle, where every free-list cell
// compares its size against the request, and an update cycle, where the
// first hit is picked along the cell chain and the lists shift. The result
// is valid the cycle after the update; one request is worked at a time, so
// the next request is accepted only after the update is done.
// A result waiting in the output register does not block the next accept;
// the update cycle holds only while the output register is occupied and rsp_ready is low.
// Reset (synchronous) empties both lists, clears the bump pointer and
// counters, and sets the heap limit to 65536.
module first_fit_chunk_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [ffca_pkg::SIZE_W-1:0]          req_req_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ffca_pkg::ADDR_BITS-1:0]       rsp_address,
   output logic [ffca_pkg::SIZE_W-1:0]          rsp_chunk_size,
   output logic [ffca_pkg::STAT_W-1:0]          rsp_status,
   output logic [ffca_pkg::CTR_W-1:0]           rsp_alloc_count,
   output logic [ffca_pkg::CTR_W-1:0]           rsp_free_count_total,
   input  logic                                 csr_wr_en,
   input  logic [ffca_pkg::HEAP_W-1:0]          csr_wr_data
);

   ffca_pkg::state_type state_ff, state_in;

   logic                            func_ff;
   logic [ffca_pkg::SIZE_W-1:0]     size_ff;
   logic [ffca_pkg::CNT_W-1:0]      free_cnt_ff, free_cnt_in;
   logic [ffca_pkg::CNT_W-1:0]      used_cnt_ff, used_cnt_in;
   logic [ffca_pkg::BUMP_W-1:0]     bump_ff, bump_in;
   logic [ffca_pkg::CTR_W-1:0]      alloc_cnt_ff, alloc_cnt_in;
   logic [ffca_pkg::CTR_W-1:0]      free_tot_ff, free_tot_in;
   logic [ffca_pkg::HEAP_W-1:0]     heap_limit_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ffca_pkg::ADDR_BITS-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [ffca_pkg::SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [ffca_pkg::STAT_W-1:0]     rsp_stat_ff, rsp_stat_in;

   ffca_pkg::free_ctl_type          free_ctl;
   ffca_pkg::stack_ctl_type         stack_ctl;
   ffca_pkg::entry_type             app_entry, push_entry, sel_entry, top_entry;
   logic                            found;
   logic                            go;
   logic [ffca_pkg::SIZE_W-1:0]     cls;
   logic [ffca_pkg::CMP_W-1:0]      bump_end;
   logic                            fits;
   logic                            slots_full;

   assign req_ready = (state_ff == ffca_pkg::FSM_IDLE);
   assign go        = (state_ff == ffca_pkg::FSM_UPDATE) && (!rsp_valid_ff || rsp_ready);

   assign cls        = ffca_pkg::size_class(size_ff);
   assign bump_end   = ffca_pkg::CMP_W'(bump_ff) + ffca_pkg::CMP_W'(cls);
   assign fits       = (bump_end <= ffca_pkg::CMP_W'(heap_limit_ff)) &&
                       (bump_end <= (ffca_pkg::CMP_W'(1) << ffca_pkg::ADDR_BITS));
   assign slots_full = (ffca_pkg::SLOT_W'(free_cnt_ff) + ffca_pkg::SLOT_W'(used_cnt_ff)) >=
                       ffca_pkg::SLOT_W'(ffca_pkg::MAX_CHUNKS);

   ffca_free_chain u_free (
      .clock     (clock),
      .reset     (reset),
      .ctl       (free_ctl),
      .req_size  (req_req_size),
      .app_entry (app_entry),
      .free_cnt  (free_cnt_ff),
      .found     (found),
      .sel_entry (sel_entry)
   );

   ffca_used_stack u_used (
      .clock      (clock),
      .ctl        (stack_ctl),
      .push_entry (push_entry),
      .top        (top_entry)
   );

   assign app_entry = top_entry;

   always_comb begin
      state_in           = state_ff;
      free_ctl.match_en  = 1'b0;
      free_ctl.remove    = 1'b0;
      free_ctl.append    = 1'b0;
      stack_ctl.push     = 1'b0;
      stack_ctl.pop      = 1'b0;
      push_entry         = sel_entry;
      free_cnt_in        = free_cnt_ff;
      used_cnt_in        = used_cnt_ff;
      bump_in            = bump_ff;
      alloc_cnt_in       = alloc_cnt_ff;
      free_tot_in        = free_tot_ff;
      rsp_addr_in        = rsp_addr_ff;
      rsp_size_in        = rsp_size_ff;
      rsp_stat_in        = rsp_stat_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ffca_pkg::FSM_IDLE: begin
            if (req_valid) begin
               free_ctl.match_en = 1'b1;
               state_in          = ffca_pkg::FSM_UPDATE;
            end
         end
         ffca_pkg::FSM_UPDATE: begin
            if (go) begin
               state_in     = ffca_pkg::FSM_IDLE;
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               rsp_size_in  = '0;
               if (func_ff == ffca_pkg::FUNC_FREE) begin
                  if (used_cnt_ff == '0 ||
                      free_cnt_ff >= ffca_pkg::CNT_W'(ffca_pkg::MAX_CHUNKS)) begin
                     rsp_stat_in = ffca_pkg::STAT_EMPTY;
                  end else begin
                     stack_ctl.pop   = 1'b1;
                     free_ctl.append = 1'b1;
                     used_cnt_in     = used_cnt_ff - ffca_pkg::CNT_W'(1);
                     free_cnt_in     = free_cnt_ff + ffca_pkg::CNT_W'(1);
                     free_tot_in     = free_tot_ff + ffca_pkg::CTR_W'(1);
                     rsp_addr_in     = top_entry.addr;
                     rsp_size_in     = top_entry.size;
                     rsp_stat_in     = ffca_pkg::STAT_REUSED;
                  end
               end else if (size_ff > ffca_pkg::CLASS_512) begin
                  rsp_stat_in = ffca_pkg::STAT_TOO_LARGE;
               end else if (found && used_cnt_ff < ffca_pkg::CNT_W'(ffca_pkg::MAX_CHUNKS)) begin
                  free_ctl.remove = 1'b1;
                  stack_ctl.push  = 1'b1;
                  free_cnt_in     = free_cnt_ff - ffca_pkg::CNT_W'(1);
                  used_cnt_in     = used_cnt_ff + ffca_pkg::CNT_W'(1);
                  rsp_addr_in     = sel_entry.addr;
                  rsp_size_in     = sel_entry.size;
                  rsp_stat_in     = ffca_pkg::STAT_REUSED;
               end else if (slots_full || !fits) begin
                  rsp_stat_in = ffca_pkg::STAT_NO_SPACE;
               end else begin
                  stack_ctl.push  = 1'b1;
                  push_entry.addr = bump_ff[ffca_pkg::ADDR_BITS-1:0];
                  push_entry.size = cls;
                  used_cnt_in     = used_cnt_ff + ffca_pkg::CNT_W'(1);
                  alloc_cnt_in    = alloc_cnt_ff + ffca_pkg::CTR_W'(1);
                  bump_in         = bump_end[ffca_pkg::BUMP_W-1:0];
                  rsp_addr_in     = bump_ff[ffca_pkg::ADDR_BITS-1:0];
                  rsp_size_in     = cls;
                  rsp_stat_in     = ffca_pkg::STAT_NEW;
               end
            end
         end
         default: begin
            state_in = ffca_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffca_pkg::FSM_IDLE;
         free_cnt_ff   <= '0;
         used_cnt_ff   <= '0;
         bump_ff       <= '0;
         alloc_cnt_ff  <= '0;
         free_tot_ff   <= '0;
         heap_limit_ff <= ffca_pkg::HEAP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_cnt_ff   <= free_cnt_in;
         used_cnt_ff   <= used_cnt_in;
         bump_ff       <= bump_in;
         alloc_cnt_ff  <= alloc_cnt_in;
         free_tot_ff   <= free_tot_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            heap_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         size_ff <= req_req_size;
      end
      rsp_addr_ff <= rsp_addr_in;
      rsp_size_ff <= rsp_size_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_address          = rsp_addr_ff;
   assign rsp_chunk_size       = rsp_size_ff;
   assign rsp_status           = rsp_stat_ff;
   // counters only move when a new result is loaded, so the live values are this result's values
   assign rsp_alloc_count      = alloc_cnt_ff;
   assign rsp_free_count_total = free_tot_ff;

endmodule

// File: hdl/ffca_checker.sv
module ffca_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [ffca_pkg::ADDR_BITS-1:0]       rsp_address,
   input logic [ffca_pkg::SIZE_W-1:0]          rsp_chunk_size,
   input logic [ffca_pkg::STAT_W-1:0]          rsp_status
);

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_accept_blocks_next : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in work");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ffca_pkg::STAT_TOO_LARGE ||
                    rsp_status == ffca_pkg::STAT_NO_SPACE ||
                    rsp_status == ffca_pkg::STAT_EMPTY)
      |-> rsp_address == '0 && rsp_chunk_size == '0)
      else $error("error result carries a chunk");

   a_new_is_class : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ffca_pkg::STAT_NEW
      |-> rsp_chunk_size == ffca_pkg::CLASS_32 || rsp_chunk_size == ffca_pkg::CLASS_64 ||
          rsp_chunk_size == ffca_pkg::CLASS_128 || rsp_chunk_size == ffca_pkg::CLASS_256 ||
          rsp_chunk_size == ffca_pkg::CLASS_512)
      else $error("new chunk is not a size class");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_address    (rsp_address),
   .rsp_chunk_size (rsp_chunk_size),
   .rsp_status     (rsp_status)
);
